// ----- hdl/spims_pkg.sv -----
package spims_pkg;

  // Largest transfer in bytes; the shift registers are sized from it.
  localparam int MAX_BYTES = 4;
  localparam int WORD_W    = 8 * MAX_BYTES;
  localparam int BITS_W    = $clog2(WORD_W + 1);

  // Fixed field widths.
  localparam int TX_W       = 32;
  localparam int RX_W       = 32;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  // Item kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPI_MODE  = 1'b0,
    CFG_MSB_FIRST = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  kind;
    logic [TX_W-1:0]       tx_word;
    logic [COUNT_W-1:0]    byte_count;
    logic                  miso;
  } in_item_t;

  typedef struct packed {
    logic                  sclk;
    logic                  mosi;
    logic                  busy_res;
    logic                  done_res;
    logic [RX_W-1:0]       rx_word;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// ----- hdl/spims_in_stage.sv -----
module spims_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  spims_pkg::in_item_t in_item,
  input  logic                take,
  output logic                full,
  output spims_pkg::in_item_t held
);

  // Take a new item whenever the slot is empty or is being drained.
  assign in_stall = full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held <= in_item;
    end
  end

endmodule

// ----- hdl/spims_core.sv -----
module spims_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  spims_pkg::in_item_t  item,
  input  spims_pkg::cfg_wr_t   cfg,
  output spims_pkg::out_item_t res
);

  localparam int W  = spims_pkg::WORD_W;
  localparam int BW = spims_pkg::BITS_W;

  logic [W-1:0]  tx_shift, tx_shift_next;
  logic [W-1:0]  rx_shift, rx_shift_next;
  logic [BW-1:0] bits_left, bits_left_next;
  logic          half_phase, half_phase_next;
  logic          active, active_next;
  logic          clock_level, clock_level_next;
  logic          data_level, data_level_next;
  logic [1:0]    spi_mode;
  logic          msb_first;
  logic [1:0]    run_mode, run_mode_next;
  logic          run_msb, run_msb_next;
  logic          done;

  logic [BW-1:0] width_bits;
  logic [W-1:0]  word_masked;
  logic          cpol, cpha;

  // Transfer length in bits; zero counts as one byte, large counts saturate.
  always_comb begin
    if (item.byte_count == '0) begin
      width_bits = BW'(8);
    end else if (int'(item.byte_count) > spims_pkg::MAX_BYTES) begin
      width_bits = BW'(W);
    end else begin
      width_bits = BW'(8 * int'(item.byte_count));
    end
    word_masked = W'(item.tx_word) & ~({W{1'b1}} << width_bits);
  end

  assign cpol = run_mode[1];
  assign cpha = run_mode[0];

  always_comb begin
    tx_shift_next    = tx_shift;
    rx_shift_next    = rx_shift;
    bits_left_next   = bits_left;
    half_phase_next  = half_phase;
    active_next      = active;
    clock_level_next = clock_level;
    data_level_next  = data_level;
    run_mode_next    = run_mode;
    run_msb_next     = run_msb;
    done             = 1'b0;

    if (item.kind == spims_pkg::KIND_START) begin
      if (!active) begin
        run_mode_next    = spi_mode;
        run_msb_next     = msb_first;
        // MSB first: left-justify so the first bit sits at the top.
        tx_shift_next    = msb_first ? (word_masked << (BW'(W) - width_bits)) : word_masked;
        rx_shift_next    = '0;
        bits_left_next   = width_bits;
        half_phase_next  = 1'b0;
        active_next      = 1'b1;
        clock_level_next = spi_mode[1];
        if (!spi_mode[0]) begin
          data_level_next = msb_first ? tx_shift_next[W-1] : tx_shift_next[0];
          tx_shift_next   = msb_first ? (tx_shift_next << 1) : (tx_shift_next >> 1);
        end
      end
    end else if (active) begin
      if (!half_phase) begin
        // leading edge
        clock_level_next = ~cpol;
        if (!cpha) begin
          rx_shift_next = {rx_shift[W-2:0], item.miso};
        end else begin
          data_level_next = run_msb ? tx_shift[W-1] : tx_shift[0];
          tx_shift_next   = run_msb ? (tx_shift << 1) : (tx_shift >> 1);
        end
        half_phase_next = 1'b1;
      end else begin
        // trailing edge
        clock_level_next = cpol;
        if (cpha) begin
          rx_shift_next = {rx_shift[W-2:0], item.miso};
        end
        half_phase_next = 1'b0;
        if (bits_left != '0) begin
          bits_left_next = bits_left - BW'(1);
        end
        if (bits_left_next == '0) begin
          active_next = 1'b0;
          done        = 1'b1;
        end else if (!cpha) begin
          data_level_next = run_msb ? tx_shift[W-1] : tx_shift[0];
          tx_shift_next   = run_msb ? (tx_shift << 1) : (tx_shift >> 1);
        end
      end
    end
  end

  always_comb begin
    res.sclk     = clock_level_next;
    res.mosi     = data_level_next;
    res.busy_res = active_next;
    res.done_res = done;
    res.rx_word  = done ? spims_pkg::RX_W'(rx_shift_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift    <= '0;
      rx_shift    <= '0;
      bits_left   <= '0;
      half_phase  <= 1'b0;
      active      <= 1'b0;
      clock_level <= 1'b0;
      data_level  <= 1'b0;
      spi_mode    <= 2'd0;
      msb_first   <= 1'b1;
      run_mode    <= 2'd0;
      run_msb     <= 1'b0;
    end else begin
      if (advance) begin
        tx_shift    <= tx_shift_next;
        rx_shift    <= rx_shift_next;
        bits_left   <= bits_left_next;
        half_phase  <= half_phase_next;
        active      <= active_next;
        clock_level <= clock_level_next;
        data_level  <= data_level_next;
        run_mode    <= run_mode_next;
        run_msb     <= run_msb_next;
      end
      if (cfg.we) begin
        if (cfg.index == spims_pkg::CFG_SPI_MODE) begin
          spi_mode <= cfg.data[1:0];
          // idle clock follows the new polarity right away
          if (!active) begin
            clock_level <= cfg.data[1];
          end
        end else if (cfg.index == spims_pkg::CFG_MSB_FIRST) begin
          msb_first <= cfg.data[0];
        end
      end
    end
  end

  a_active_has_bits: assert property (@(posedge clk) disable iff (rst)
    active |-> (bits_left != '0))
    else $error("active transfer with no bits left");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    !active |-> !half_phase)
    else $error("idle with half phase set");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && res.done_res) |=> !active)
    else $error("transfer still active after done");

endmodule

// ----- hdl/spims_out_stage.sv -----
module spims_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  spims_pkg::out_item_t res,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spims_pkg::out_item_t held
);

  // Slot frees up when empty or when the held item leaves this cycle.
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= res;
    end
  end

endmodule

// ----- hdl/spi_master_shift_engine_top.sv -----
// SPI master shift engine for modes 0 to 3. A start item (kind 1) loads a
// 1 to 4 byte word and its byte count; each tick item (kind 0) is one half
// bit period, and every accepted item returns exactly one result item with
// the sclk and mosi pin levels after that item, busy, done, and on done the
// received word (first bit received at bit 8*byte_count-1). Mode and bit
// order come from the spi_mode and msb_first registers and are latched at
// start; writing spi_mode while no transfer runs moves the held clock level
// to the new idle level, and sclk shows it in the next result item. A start
// while busy and a tick while idle leave the state as it is. Rate: one item
// per clock while the result side does not stall. Each item passes through
// the input register, then the pin state update in the core, which feeds
// the result register. Both channels are valid/stall; in_stall rises only
// when both registers are full and the result side stalls.
module spi_master_shift_engine_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [spims_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spims_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic [spims_pkg::TX_W-1:0]           tx_word,
  input  logic [spims_pkg::COUNT_W-1:0]        byte_count,
  input  logic                                 miso,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 sclk,
  output logic                                 mosi,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic [spims_pkg::RX_W-1:0]           rx_word
);

  spims_pkg::in_item_t  in_item;
  spims_pkg::in_item_t  held_item;
  spims_pkg::out_item_t core_res;
  spims_pkg::out_item_t out_item;
  spims_pkg::cfg_wr_t   cfg;
  logic                 in_full;
  logic                 out_ready;
  logic                 advance;

  assign in_item.kind       = kind;
  assign in_item.tx_word    = tx_word;
  assign in_item.byte_count = byte_count;
  assign in_item.miso       = miso;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // An item moves from the input register into the core whenever the result
  // register can take its result in the same cycle.
  assign advance = in_full && out_ready;

  spims_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (out_ready),
    .full     (in_full),
    .held     (held_item)
  );

  spims_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .cfg     (cfg),
    .res     (core_res)
  );

  spims_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (core_res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (out_item)
  );

  assign sclk     = out_item.sclk;
  assign mosi     = out_item.mosi;
  assign busy_res = out_item.busy_res;
  assign done_res = out_item.done_res;
  assign rx_word  = out_item.rx_word;

endmodule
